/* hw/rtl/cdt_pkg.sv */
// Package for the countdown timer peripheral.
// Holds the action and register codes, control bit positions and reset values.
// No dependencies.
package cdt_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CtlW  = 8;
  localparam int unsigned PscW  = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CtlW-1:0]  ctl_t;
  typedef logic [PscW-1:0]  psc_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_LOAD   = 3'd0,
    REG_VALUE  = 3'd1,
    REG_CTRL   = 3'd2,
    REG_CLEAR  = 3'd3,
    REG_RAW    = 3'd4,
    REG_MASKED = 3'd5,
    REG_BGLOAD = 3'd6
  } reg_index_t;

  // Bit positions in the control word.
  localparam int unsigned CtlEnableBit   = 7;
  localparam int unsigned CtlPeriodicBit = 6;
  localparam int unsigned CtlIntEnBit    = 5;
  localparam int unsigned CtlPscLsb      = 2;
  localparam int unsigned CtlSize32Bit   = 1;
  localparam int unsigned CtlOneShotBit  = 0;

  localparam logic [1:0] PSC_DIV1   = 2'b00;
  localparam logic [1:0] PSC_DIV16  = 2'b01;

  localparam psc_t PscLimDiv1   = 8'd0;
  localparam psc_t PscLimDiv16  = 8'd15;
  localparam psc_t PscLimDiv256 = 8'd255;

  localparam word_t WordMax  = 32'hFFFF_FFFF;
  localparam word_t HalfMask = 32'h0000_FFFF;
  localparam ctl_t  CtlReset = 8'h20;

endpackage

/* hw/rtl/cdt_in_if.sv */
// Input channel of the countdown timer: one word is a tick, a read or a write.
// Depends on cdt_pkg.
interface cdt_in_if;
  import cdt_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] reg_index;
  word_t      write_data;

  modport source (output valid, output action, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input action, input reg_index, input write_data,
                output ready);
endinterface

/* hw/rtl/cdt_out_if.sv */
// Result channel of the countdown timer: read data and the masked interrupt.
// Depends on cdt_pkg.
interface cdt_out_if;
  import cdt_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_data;
  logic  irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink (input valid, input read_data, input irq, output ready);
endinterface

/* hw/rtl/countdown_timer_peripheral.sv */
// One channel of a dual countdown timer with load, value, control, clear,
// status and background load registers. Depends on cdt_pkg, cdt_in_if, cdt_out_if.
//
//   channel   direction  word contents
//   in_ch     input      action, reg_index, write_data
//   out_ch    output     read_data, irq
//
// Each accepted word updates the timer state and loads the output register in
// the same cycle, so one word is taken per clock unless out_ch stalls, and its
// result shows in the next cycle. The output register frees itself when
// out_ch.ready is high, so input is taken whenever the output is empty or being
// drained at that edge. Synchronous active-low reset restores the register reset
// values and empties the output register.
module countdown_timer_peripheral (
  input  logic clk,
  input  logic rst_n,
  cdt_in_if.sink    in_ch,
  cdt_out_if.source out_ch
);
  import cdt_pkg::*;

  word_t load_r, load_nxt;
  word_t count_r, count_nxt;
  ctl_t  ctl_r, ctl_nxt;
  logic  raw_r, raw_nxt;
  psc_t  psc_r, psc_nxt;

  logic  out_valid_r;
  word_t out_data_r, out_data_nxt;
  logic  out_irq_r, out_irq_nxt;

  logic  accept;
  psc_t  psc_lim;
  word_t size_mask;
  word_t cnt_masked;
  word_t cnt_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (ctl_r[CtlPscLsb +: 2])
      PSC_DIV1:  psc_lim = PscLimDiv1;
      PSC_DIV16: psc_lim = PscLimDiv16;
      default:   psc_lim = PscLimDiv256;
    endcase
  end

  assign size_mask  = ctl_r[CtlSize32Bit] ? WordMax : HalfMask;
  assign cnt_masked = count_r & size_mask;
  assign cnt_dec    = (cnt_masked - 32'd1) & size_mask;

  always_comb begin
    load_nxt     = load_r;
    count_nxt    = count_r;
    ctl_nxt      = ctl_r;
    raw_nxt      = raw_r;
    psc_nxt      = psc_r;
    out_data_nxt = '0;
    unique case (in_ch.action)
      ACT_TICK: begin
        if (ctl_r[CtlEnableBit]) begin
          if (psc_r >= psc_lim) begin
            psc_nxt = '0;
            if (cnt_masked == '0) begin
              // Terminal count already reached: halt, reload or wrap.
              priority if (ctl_r[CtlOneShotBit]) begin
                count_nxt = '0;
              end else if (ctl_r[CtlPeriodicBit]) begin
                count_nxt = load_r & size_mask;
              end else begin
                count_nxt = size_mask;
              end
            end else begin
              count_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                raw_nxt = 1'b1;
              end
            end
          end else begin
            psc_nxt = psc_r + 8'd1;
          end
        end
      end
      ACT_READ: begin
        unique case (in_ch.reg_index)
          REG_LOAD:   out_data_nxt = load_r;
          REG_VALUE:  out_data_nxt = count_r;
          REG_CTRL:   out_data_nxt = {{(WordW-CtlW){1'b0}}, ctl_r};
          REG_RAW:    out_data_nxt = {{(WordW-1){1'b0}}, raw_r};
          REG_MASKED: out_data_nxt = {{(WordW-1){1'b0}}, raw_r & ctl_r[CtlIntEnBit]};
          REG_BGLOAD: out_data_nxt = load_r;
          default:    out_data_nxt = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (in_ch.reg_index)
          REG_LOAD: begin
            load_nxt  = in_ch.write_data;
            count_nxt = in_ch.write_data;
            psc_nxt   = '0;
          end
          REG_CTRL:   ctl_nxt  = in_ch.write_data[CtlW-1:0];
          REG_CLEAR:  raw_nxt  = 1'b0;
          REG_BGLOAD: load_nxt = in_ch.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    out_irq_nxt = raw_nxt & ctl_nxt[CtlIntEnBit];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r      <= '0;
      count_r     <= WordMax;
      ctl_r       <= CtlReset;
      raw_r       <= 1'b0;
      psc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        load_r      <= load_nxt;
        count_r     <= count_nxt;
        ctl_r       <= ctl_nxt;
        raw_r       <= raw_nxt;
        psc_r       <= psc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_irq_r  <= out_irq_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.irq       = out_irq_r;

endmodule
